[sv/tgd_pkg.sv]
// Shared types, codes and reset values for the touch gesture detector.
// No dependencies; the design and checker files refer to it by scoped names.
package tgd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = 3;
    localparam int PADDR_W       = 5;

    // Register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_DROP_THR   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DTAP_WIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_TAP    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BASE_INTV  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WARMUP     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_SLOW = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_FAST = 3'd7;

    localparam logic [15:0] RST_DROP_THR   = 16'd35;
    localparam logic [15:0] RST_HOLD_TIME  = 16'd2000;
    localparam logic [15:0] RST_DTAP_WIN   = 16'd500;
    localparam logic [15:0] RST_MIN_TAP    = 16'd20;
    localparam logic [15:0] RST_BASE_INTV  = 16'd200;
    localparam logic [15:0] RST_WARMUP     = 16'd5000;
    localparam logic [15:0] RST_ALPHA_SLOW = 16'd9830;
    localparam logic [15:0] RST_ALPHA_FAST = 16'd32768;

    typedef enum logic [1:0] {
        MODE_CAL_BEGIN  = 2'd0,
        MODE_CAL_SAMPLE = 2'd1,
        MODE_ARM        = 2'd2,
        MODE_RUN        = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        GS_IDLE     = 2'd0,
        GS_TOUCHING = 2'd1,
        GS_WAIT     = 2'd2,
        GS_HOLD     = 2'd3
    } gest_state_t;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_TAP    = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;
    localparam logic [1:0] EV_HOLD   = 2'd3;

    typedef struct packed {
        logic [15:0] drop_threshold;
        logic [15:0] hold_time_ms;
        logic [15:0] dtap_gap_ms;
        logic [15:0] min_tap_ms;
        logic [15:0] baseline_interval_ms;
        logic [15:0] warmup_ms;
        logic [15:0] alpha_slow;
        logic [15:0] alpha_fast;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] sample;
        logic [31:0] now_ms;
    } item_t;

endpackage

[sv/tgd_if.sv]
// Valid/ready channel interfaces for input items and results.
// Standalone; the top level has one port of each.
interface tgd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] sample;
    logic [31:0] now_ms;

    modport source (output valid, mode, sample, now_ms, input ready);
    modport sink   (input valid, mode, sample, now_ms, output ready);
endinterface

interface tgd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic        touched;
    logic [15:0] baseline_level;

    modport source (output valid, event_res, touched, baseline_level, input ready);
    modport sink   (input valid, event_res, touched, baseline_level, output ready);
endinterface

[sv/touch_gesture_detector.sv]
// Top level of the capacitive touch gesture detector.
// Depends on tgd_pkg, tgd_if, tgd_cfg_regs, tgd_baseline and tgd_gesture_fsm.
//
//   channel   direction  handshake        payload
//   in_ch     sink       valid / ready    mode, sample, now_ms
//   out_ch    source     valid / ready    event_res, touched, baseline_level
//   APB       slave      psel / penable   paddr, pwdata, prdata (pready tied high)
//
// Throughput is one transaction per cycle while out_ch.ready is not held low;
// an item passes the input register and then the result register. The baseline
// and gesture state update in the same cycle the item moves from the input register
// to the result register, so each item sees the state its predecessor left.
// Reset clears the valid flags, baseline and gesture state at once; there is no
// clearing pass. When the result register is full and out_ch.ready is low, hold it
// and the input register and drop in_ch.ready once the input register is occupied.
module touch_gesture_detector #(
    parameter int FRAC_BITS = tgd_pkg::FRAC_BITS_DEF,
    parameter int TIME_BITS = tgd_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tgd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    tgd_in_if.sink                      in_ch,
    tgd_out_if.source                   out_ch
);

    tgd_pkg::cfg_t  cfg;
    tgd_pkg::item_t item_reg, item_next;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic [1:0]     event_reg, event_next;
    logic           touched_reg, touched_next;
    logic [15:0]    level_reg, level_next;
    logic           advance;
    logic           process;
    logic           armed;

    // Advance the result stage whenever it is empty or being drained
    assign advance     = !out_valid_reg || out_ch.ready;
    assign process     = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    assign item_next.mode   = tgd_pkg::mode_t'(in_ch.mode);
    assign item_next.sample = in_ch.sample;
    assign item_next.now_ms = in_ch.now_ms;

    tgd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgd_baseline #(
        .FRAC_BITS (FRAC_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_base (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (process),
        .item       (item_reg),
        .armed      (armed),
        .cfg        (cfg),
        .touched    (touched_next),
        .level_next (level_next)
    );

    tgd_gesture_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (process),
        .item      (item_reg),
        .touched   (touched_next),
        .cfg       (cfg),
        .armed     (armed),
        .event_res (event_next)
    );

    // Input register: take a transaction whenever there is room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            item_reg <= item_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            event_reg   <= event_next;
            touched_reg <= touched_next;
            level_reg   <= level_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.event_res      = event_reg;
    assign out_ch.touched        = touched_reg;
    assign out_ch.baseline_level = level_reg;

endmodule

[sv/tgd_cfg_regs.sv]
// APB-style configuration register file for the gesture detector.
// Depends on tgd_pkg for register indexes, reset values and cfg_t.
module tgd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tgd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output tgd_pkg::cfg_t               cfg
);

    tgd_pkg::cfg_t                 cfg_reg;
    logic [tgd_pkg::REG_IDX_W-1:0] idx;
    logic                          wr_en;
    logic [15:0]                   rd_val;

    assign pready = 1'b1;
    assign idx    = paddr[tgd_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drop_threshold       <= tgd_pkg::RST_DROP_THR;
            cfg_reg.hold_time_ms         <= tgd_pkg::RST_HOLD_TIME;
            cfg_reg.dtap_gap_ms          <= tgd_pkg::RST_DTAP_WIN;
            cfg_reg.min_tap_ms           <= tgd_pkg::RST_MIN_TAP;
            cfg_reg.baseline_interval_ms <= tgd_pkg::RST_BASE_INTV;
            cfg_reg.warmup_ms            <= tgd_pkg::RST_WARMUP;
            cfg_reg.alpha_slow           <= tgd_pkg::RST_ALPHA_SLOW;
            cfg_reg.alpha_fast           <= tgd_pkg::RST_ALPHA_FAST;
        end
        else if (wr_en)
        begin
            case (idx)
                tgd_pkg::REG_DROP_THR:   cfg_reg.drop_threshold       <= pwdata[15:0];
                tgd_pkg::REG_HOLD_TIME:  cfg_reg.hold_time_ms         <= pwdata[15:0];
                tgd_pkg::REG_DTAP_WIN:   cfg_reg.dtap_gap_ms          <= pwdata[15:0];
                tgd_pkg::REG_MIN_TAP:    cfg_reg.min_tap_ms           <= pwdata[15:0];
                tgd_pkg::REG_BASE_INTV:  cfg_reg.baseline_interval_ms <= pwdata[15:0];
                tgd_pkg::REG_WARMUP:     cfg_reg.warmup_ms            <= pwdata[15:0];
                tgd_pkg::REG_ALPHA_SLOW: cfg_reg.alpha_slow           <= pwdata[15:0];
                tgd_pkg::REG_ALPHA_FAST: cfg_reg.alpha_fast           <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tgd_pkg::REG_DROP_THR:   rd_val = cfg_reg.drop_threshold;
            tgd_pkg::REG_HOLD_TIME:  rd_val = cfg_reg.hold_time_ms;
            tgd_pkg::REG_DTAP_WIN:   rd_val = cfg_reg.dtap_gap_ms;
            tgd_pkg::REG_MIN_TAP:    rd_val = cfg_reg.min_tap_ms;
            tgd_pkg::REG_BASE_INTV:  rd_val = cfg_reg.baseline_interval_ms;
            tgd_pkg::REG_WARMUP:     rd_val = cfg_reg.warmup_ms;
            tgd_pkg::REG_ALPHA_SLOW: rd_val = cfg_reg.alpha_slow;
            tgd_pkg::REG_ALPHA_FAST: rd_val = cfg_reg.alpha_fast;
            default:                 rd_val = 16'd0;
        endcase
    end

    assign prdata = {16'd0, rd_val};

endmodule

[sv/tgd_baseline.sv]
// Adaptive baseline: calibration, touch decision and exponential averaging.
// Depends on tgd_pkg for mode codes, cfg_t and item_t.
module tgd_baseline #(
    parameter int FRAC_BITS = tgd_pkg::FRAC_BITS_DEF,
    parameter int TIME_BITS = tgd_pkg::TIME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  tgd_pkg::item_t item,
    input  logic          armed,
    input  tgd_pkg::cfg_t  cfg,
    output logic          touched,
    output logic [15:0]   level_next
);

    localparam int BW = 16 + FRAC_BITS;
    localparam int AW = BW + 18;
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(32768);

    logic [BW-1:0]          base_reg, base_next;
    logic [TIME_BITS-1:0]   last_upd_reg, last_upd_next;
    logic [TIME_BITS-1:0]   warm_start_reg, warm_start_next;
    logic [TIME_BITS-1:0]   now;
    logic [BW-1:0]          sfix, b0;
    logic signed [17:0]     delta;
    logic                   run, touch_i, upd, warm;
    logic [15:0]            alpha;
    logic signed [BW:0]     diff;
    logic signed [AW-1:0]   prod, acc;
    logic [BW-1:0]          blended;

    assign now  = item.now_ms[TIME_BITS-1:0];
    assign sfix = {item.sample, {FRAC_BITS{1'b0}}};
    assign run  = (item.mode == tgd_pkg::MODE_RUN) && armed;

    // A zero baseline on a run sample snaps to the sample first
    assign b0      = (base_reg == '0) ? sfix : base_reg;
    assign delta   = $signed({2'b00, b0[BW-1 -: 16]}) - $signed({2'b00, item.sample});
    assign touch_i = delta >= $signed({2'b00, cfg.drop_threshold});
    assign touched = run && touch_i;

    assign upd   = (now - last_upd_reg) >= TIME_BITS'(cfg.baseline_interval_ms);
    assign warm  = (now - warm_start_reg) < TIME_BITS'(cfg.warmup_ms);
    assign alpha = warm ? cfg.alpha_fast : cfg.alpha_slow;

    // old + alpha * (new - old), in Q16 weight, rounded half up
    assign diff    = $signed({1'b0, sfix}) - $signed({1'b0, b0});
    assign prod    = $signed({1'b0, alpha}) * diff;
    assign acc     = $signed({2'b00, b0, 16'd0}) + prod + ROUND_HALF;
    assign blended = acc[16 +: BW];

    always_comb
    begin
        base_next       = base_reg;
        last_upd_next   = last_upd_reg;
        warm_start_next = warm_start_reg;
        case (item.mode)
            tgd_pkg::MODE_CAL_BEGIN:
            begin
                base_next = '0;
            end
            tgd_pkg::MODE_CAL_SAMPLE:
            begin
                if (sfix > base_reg)
                    base_next = sfix;
            end
            tgd_pkg::MODE_ARM:
            begin
                warm_start_next = now;
            end
            default:
            begin
                if (armed)
                begin
                    base_next = b0;
                    if (!touch_i && upd)
                    begin
                        base_next     = blended;
                        last_upd_next = now;
                    end
                end
            end
        endcase
    end

    assign level_next = base_next[BW-1 -: 16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            last_upd_reg   <= '0;
            warm_start_reg <= '0;
        end
        else if (en)
        begin
            base_reg       <= base_next;
            last_upd_reg   <= last_upd_next;
            warm_start_reg <= warm_start_next;
        end
    end

endmodule

[sv/tgd_gesture_fsm.sv]
// Tap / double tap / hold state machine and the armed flag.
// Depends on tgd_pkg for state, mode and event codes and cfg_t.
module tgd_gesture_fsm #(
    parameter int TIME_BITS = tgd_pkg::TIME_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  tgd_pkg::item_t item,
    input  logic           touched,
    input  tgd_pkg::cfg_t  cfg,
    output logic           armed,
    output logic [1:0]     event_res
);

    tgd_pkg::gest_state_t state_reg, state_next;
    logic                 armed_reg, armed_next;
    logic                 late_reg, late_next;
    logic [TIME_BITS-1:0] press_reg, press_next;
    logic [TIME_BITS-1:0] rel_reg, rel_next;
    logic [TIME_BITS-1:0] now, d_press, d_rel;
    logic                 long_press;

    assign now        = item.now_ms[TIME_BITS-1:0];
    assign d_press    = now - press_reg;
    assign d_rel      = now - rel_reg;
    assign long_press = d_press >= TIME_BITS'(cfg.hold_time_ms);
    assign armed      = armed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgd_pkg::GS_IDLE;
            armed_reg <= 1'b0;
            late_reg  <= 1'b0;
            press_reg <= '0;
            rel_reg   <= '0;
        end
        else if (en)
        begin
            state_reg <= state_next;
            armed_reg <= armed_next;
            late_reg  <= late_next;
            press_reg <= press_next;
            rel_reg   <= rel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        armed_next = armed_reg;
        late_next  = late_reg;
        press_next = press_reg;
        rel_next   = rel_reg;
        event_res  = tgd_pkg::EV_NONE;
        if (item.mode == tgd_pkg::MODE_ARM)
        begin
            armed_next = 1'b1;
            state_next = tgd_pkg::GS_IDLE;
        end
        else if (item.mode == tgd_pkg::MODE_RUN && armed_reg)
        begin
            case (state_reg)
                tgd_pkg::GS_IDLE:
                begin
                    if (touched)
                    begin
                        state_next = tgd_pkg::GS_TOUCHING;
                        press_next = now;
                        late_next  = 1'b0;
                    end
                end
                tgd_pkg::GS_TOUCHING:
                begin
                    if (!touched)
                    begin
                        if (long_press || late_reg ||
                            d_press < TIME_BITS'(cfg.min_tap_ms))
                            state_next = tgd_pkg::GS_IDLE;
                        else
                        begin
                            rel_next   = now;
                            state_next = tgd_pkg::GS_WAIT;
                        end
                    end
                    else if (long_press)
                    begin
                        event_res  = tgd_pkg::EV_HOLD;
                        state_next = tgd_pkg::GS_HOLD;
                    end
                end
                tgd_pkg::GS_WAIT:
                begin
                    if (touched)
                    begin
                        // Second touch past the window is swallowed
                        if (d_rel <= TIME_BITS'(cfg.dtap_gap_ms))
                        begin
                            event_res = tgd_pkg::EV_DOUBLE;
                            late_next = 1'b0;
                        end
                        else
                            late_next = 1'b1;
                        state_next = tgd_pkg::GS_TOUCHING;
                        press_next = now;
                    end
                    else if (d_rel > TIME_BITS'(cfg.dtap_gap_ms))
                    begin
                        event_res  = tgd_pkg::EV_TAP;
                        state_next = tgd_pkg::GS_IDLE;
                    end
                end
                default:
                begin
                    if (!touched)
                        state_next = tgd_pkg::GS_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/tgd_checker.sv]
// Port-level checks on the result channel of the gesture detector.
// Depends on tgd_pkg for event codes; bound to touch_gesture_detector.
module tgd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  event_res,
    input logic        touched,
    input logic [15:0] baseline_level
);

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) &&
        $stable(touched) && $stable(baseline_level))
        else $error("result changed while stalled");

    // A hold fires only while the finger is still down
    a_hold_touched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == tgd_pkg::EV_HOLD |-> touched)
        else $error("hold event without touch");

    // A double tap is reported on the second press
    a_double_touched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == tgd_pkg::EV_DOUBLE |-> touched)
        else $error("double tap event without touch");

    // A single tap is reported only after release, once the window expires
    a_tap_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == tgd_pkg::EV_TAP |-> !touched)
        else $error("tap event while touched");

endmodule

bind touch_gesture_detector tgd_checker u_tgd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .event_res      (out_ch.event_res),
    .touched        (out_ch.touched),
    .baseline_level (out_ch.baseline_level)
);
